// ----- rtl/core/vgmcsp_pkg.sv -----
// Shared types and constants for the music-log command stream parser.
// No dependencies; used by every module in rtl/core.
package vgmcsp_pkg;

  typedef logic [2:0] kind_t;

  localparam kind_t KIND_WRITE   = 3'd0;
  localparam kind_t KIND_WAIT    = 3'd1;
  localparam kind_t KIND_END     = 3'd2;
  localparam kind_t KIND_STOP    = 3'd3;
  localparam kind_t KIND_SMALL   = 3'd4;
  localparam kind_t KIND_NOT_VGM = 3'd5;
  localparam kind_t KIND_BAD_OFF = 3'd6;

  // Command opcodes
  localparam logic [7:0] OP_WRITE      = 8'h51;
  localparam logic [7:0] OP_WAIT       = 8'h61;
  localparam logic [7:0] OP_WAIT_NTSC  = 8'h62;
  localparam logic [7:0] OP_WAIT_PAL   = 8'h63;
  localparam logic [7:0] OP_END        = 8'h66;
  localparam logic [7:0] OP_DATA_BLOCK = 8'h67;
  localparam logic [7:0] OP_SKIP_A     = 8'h50;
  localparam logic [7:0] OP_SKIP_B     = 8'h4F;
  localparam logic [7:0] OP_SEEK       = 8'hE0;
  localparam logic [3:0] OP_WAIT_SHORT = 4'h7;  // upper nibble of 0x7n
  localparam logic [7:0] BLOCK_SIG     = 8'h66;

  localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;

  // Header layout
  localparam logic [31:0] IDENT_WORD      = 32'h206D6756;  // "Vgm " byte 0 in low bits
  localparam logic [31:0] POS_OFFSET_LO   = 32'h34;
  localparam logic [31:0] POS_OFFSET_HI   = 32'h37;
  localparam logic [31:0] POS_DATA_MIN    = 32'h38;
  localparam logic [31:0] POS_HDR_CHECK   = 32'h3F;
  localparam logic [31:0] DATA_START_DFLT = 32'h40;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_of_file;
  } in_item_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  opcode;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [15:0] wait_samples;
  } out_item_t;

  // Header checks for the byte at hand
  typedef struct packed {
    logic cmd_en;
    logic too_small;
    logic not_vgm;
    logic bad_offset;
  } hdr_info_t;

endpackage

// ----- rtl/core/vgmcsp_hdr.sv -----
// Header tracker: byte position, ident check and data offset capture.
// Depends on vgmcsp_pkg.
module vgmcsp_hdr (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             byte_value,
  input  logic                   last_of_file,
  output vgmcsp_pkg::hdr_info_t  info
);

  logic [31:0] pos_r, pos_nxt;
  logic        ident_ok_r, ident_ok_nxt;
  logic [31:0] data_start_r, data_start_nxt;

  logic        ident_cur;
  logic [31:0] ds_shift;
  logic [31:0] ds_cur;
  logic        offset_ok;
  logic        past_start;

  always_comb begin
    ident_cur = ident_ok_r &
                ~((pos_r < 32'd4) &&
                  (byte_value != vgmcsp_pkg::IDENT_WORD[{pos_r[1:0], 3'b000} +: 8]));
    ds_shift  = {byte_value, data_start_r[31:8]};
    ds_cur    = data_start_r;
    if (pos_r == vgmcsp_pkg::POS_OFFSET_HI) begin
      ds_cur = (ds_shift == 32'd0) ? vgmcsp_pkg::DATA_START_DFLT
                                   : vgmcsp_pkg::POS_OFFSET_LO + ds_shift;
    end else if (pos_r >= vgmcsp_pkg::POS_OFFSET_LO && pos_r < vgmcsp_pkg::POS_OFFSET_HI) begin
      ds_cur = ds_shift;
    end
    offset_ok  = (pos_r >= vgmcsp_pkg::POS_OFFSET_HI) && (ds_cur >= vgmcsp_pkg::POS_DATA_MIN);
    past_start = (pos_r >= ds_cur);

    info.cmd_en     = (pos_r >= vgmcsp_pkg::POS_DATA_MIN) && ident_cur && offset_ok
                      && past_start;
    info.too_small  = last_of_file && (pos_r < vgmcsp_pkg::POS_HDR_CHECK);
    info.not_vgm    = (pos_r == vgmcsp_pkg::POS_HDR_CHECK) && !ident_cur;
    // Offset too low, or the file ends before the data starts
    info.bad_offset = ((pos_r == vgmcsp_pkg::POS_HDR_CHECK) && !offset_ok) ||
                      (last_of_file && ident_cur && offset_ok && !past_start);
  end

  always_comb begin
    pos_nxt        = pos_r;
    ident_ok_nxt   = ident_ok_r;
    data_start_nxt = data_start_r;
    if (step) begin
      if (last_of_file) begin
        pos_nxt        = 32'd0;
        ident_ok_nxt   = 1'b1;
        data_start_nxt = 32'd0;
      end else begin
        pos_nxt        = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;
        ident_ok_nxt   = ident_cur;
        data_start_nxt = ds_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= 32'd0;
      ident_ok_r   <= 1'b1;
      data_start_r <= 32'd0;
    end else begin
      pos_r        <= pos_nxt;
      ident_ok_r   <= ident_ok_nxt;
      data_start_r <= data_start_nxt;
    end
  end

endmodule

// ----- rtl/core/vgmcsp_cmd.sv -----
// Command decoder: opcode/argument phases, data block length and skip count.
// Depends on vgmcsp_pkg.
module vgmcsp_cmd (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic                   cmd_en,
  input  logic [7:0]             byte_value,
  input  logic                   last_of_file,
  output logic                   res_valid,
  output vgmcsp_pkg::out_item_t  res
);

  localparam logic [2:0] PH_OP   = 3'd0;
  localparam logic [2:0] PH_ARG1 = 3'd1;
  localparam logic [2:0] PH_ARG2 = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_SKIP = 3'd4;
  localparam logic [2:0] PH_HALT = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  opcode_r, opcode_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] skip_r, skip_nxt;

  logic [31:0] skip_dec;
  logic [31:0] len_shift;
  logic        decode;

  always_comb begin
    skip_dec  = skip_r - 32'd1;
    len_shift = {byte_value, len_r[31:8]};
    decode    = step && cmd_en;

    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    held_nxt   = held_r;
    len_nxt    = len_r;
    skip_nxt   = skip_r;
    res_valid  = 1'b0;
    res        = '0;

    if (decode) begin
      unique case (phase_r)
        PH_OP: begin
          opcode_nxt = byte_value;
          res.opcode = byte_value;
          priority if (byte_value == vgmcsp_pkg::OP_END) begin
            phase_nxt = PH_HALT;
            res_valid = 1'b1;
            res.kind  = vgmcsp_pkg::KIND_END;
          end else if (byte_value == vgmcsp_pkg::OP_WRITE || byte_value == vgmcsp_pkg::OP_WAIT ||
                       byte_value == vgmcsp_pkg::OP_DATA_BLOCK) begin
            phase_nxt = PH_ARG1;
          end else if (byte_value == vgmcsp_pkg::OP_WAIT_NTSC) begin
            res_valid        = 1'b1;
            res.kind         = vgmcsp_pkg::KIND_WAIT;
            res.wait_samples = vgmcsp_pkg::WAIT_NTSC_SAMPLES;
          end else if (byte_value == vgmcsp_pkg::OP_WAIT_PAL) begin
            res_valid        = 1'b1;
            res.kind         = vgmcsp_pkg::KIND_WAIT;
            res.wait_samples = vgmcsp_pkg::WAIT_PAL_SAMPLES;
          end else if (byte_value[7:4] == vgmcsp_pkg::OP_WAIT_SHORT) begin
            res_valid        = 1'b1;
            res.kind         = vgmcsp_pkg::KIND_WAIT;
            res.wait_samples = {12'd0, byte_value[3:0]} + 16'd1;
          end else if (byte_value == vgmcsp_pkg::OP_SKIP_A ||
                       byte_value == vgmcsp_pkg::OP_SKIP_B) begin
            skip_nxt  = 32'd1;
            phase_nxt = PH_SKIP;
          end else if (byte_value == vgmcsp_pkg::OP_SEEK) begin
            skip_nxt  = 32'd4;
            phase_nxt = PH_SKIP;
          end else begin
            // unsupported opcode: stop for the rest of the file
            phase_nxt = PH_HALT;
            res_valid = 1'b1;
            res.kind  = vgmcsp_pkg::KIND_STOP;
          end
        end
        PH_ARG1: begin
          held_nxt  = byte_value;
          phase_nxt = PH_ARG2;
        end
        PH_ARG2: begin
          phase_nxt  = PH_OP;
          res.opcode = opcode_r;
          priority if (opcode_r == vgmcsp_pkg::OP_WRITE) begin
            res_valid    = 1'b1;
            res.kind     = vgmcsp_pkg::KIND_WRITE;
            res.reg_addr = held_r;
            res.reg_data = byte_value;
          end else if (opcode_r == vgmcsp_pkg::OP_WAIT) begin
            res_valid        = 1'b1;
            res.kind         = vgmcsp_pkg::KIND_WAIT;
            res.wait_samples = {byte_value, held_r};
          end else if (held_r != vgmcsp_pkg::BLOCK_SIG) begin
            phase_nxt = PH_HALT;
            res_valid = 1'b1;
            res.kind  = vgmcsp_pkg::KIND_STOP;
          end else begin
            len_nxt   = 32'd0;
            skip_nxt  = 32'd4;
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          len_nxt  = len_shift;
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            skip_nxt  = len_shift;
            phase_nxt = (len_shift != 32'd0) ? PH_SKIP : PH_OP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = PH_OP;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // rearm for the next file
    if (step && last_of_file) begin
      phase_nxt  = PH_OP;
      opcode_nxt = 8'd0;
      held_nxt   = 8'd0;
      len_nxt    = 32'd0;
      skip_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_OP;
      opcode_r <= 8'd0;
      held_r   <= 8'd0;
      len_r    <= 32'd0;
      skip_r   <= 32'd0;
    end else begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      held_r   <= held_nxt;
      len_r    <= len_nxt;
      skip_r   <= skip_nxt;
    end
  end

endmodule

// ----- rtl/core/vgm_command_stream_parser_core.sv -----
// Top level of the music-log command stream parser.
// Depends on vgmcsp_pkg, vgmcsp_hdr and vgmcsp_cmd.

// Takes one file byte per beat and returns zero or one result per byte: chip
// register writes, waits, the end marker, a stop on an unsupported opcode or a bad
// block signature, and header errors (too small, bad ident, bad data offset). The
// block sustains one byte per clock while out_ready does not hold the output. A byte
// is held in an input register, decoded combinationally against the header and
// command state, and its result lands in an output register once that register
// is free; the result stays on out_data until out_ready takes it. in_ready is
// high while the input register is empty or the output register is free or
// being drained in the same cycle; bytes that give no result leave no output beat.
module vgm_command_stream_parser_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  vgmcsp_pkg::in_item_t   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vgmcsp_pkg::out_item_t  out_data
);

  logic                  in_valid_r, in_valid_nxt;
  vgmcsp_pkg::in_item_t  in_data_r, in_data_nxt;
  logic                  out_valid_r, out_valid_nxt;
  vgmcsp_pkg::out_item_t out_data_r, out_data_nxt;

  logic                  out_free;
  logic                  adv;
  vgmcsp_pkg::hdr_info_t hdr_info;
  logic                  cmd_valid;
  vgmcsp_pkg::out_item_t cmd_res;
  logic                  res_valid;
  vgmcsp_pkg::out_item_t res;

  assign out_free = !out_valid_r || out_ready;
  assign adv      = in_valid_r && out_free;
  assign in_ready = !in_valid_r || out_free;

  vgmcsp_hdr u_hdr (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .byte_value   (in_data_r.byte_value),
    .last_of_file (in_data_r.last_of_file),
    .info         (hdr_info)
  );

  vgmcsp_cmd u_cmd (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (adv),
    .cmd_en       (hdr_info.cmd_en),
    .byte_value   (in_data_r.byte_value),
    .last_of_file (in_data_r.last_of_file),
    .res_valid    (cmd_valid),
    .res          (cmd_res)
  );

  // Header errors override any command result of the same byte
  always_comb begin
    res       = '0;
    res_valid = 1'b1;
    priority if (hdr_info.too_small) begin
      res.kind = vgmcsp_pkg::KIND_SMALL;
    end else if (hdr_info.not_vgm) begin
      res.kind = vgmcsp_pkg::KIND_NOT_VGM;
    end else if (hdr_info.bad_offset) begin
      res.kind = vgmcsp_pkg::KIND_BAD_OFF;
    end else begin
      res       = cmd_res;
      res_valid = cmd_valid;
    end
  end

  always_comb begin
    in_valid_nxt  = in_valid_r;
    in_data_nxt   = in_data_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
      in_data_nxt  = in_data;
    end else if (adv) begin
      in_valid_nxt = 1'b0;
    end
    if (adv) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_data_nxt = res;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_data_r  <= in_data_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
